>>> src/xprd_pkg.sv
// Package: shared constants and controller/datapath handshake types for the PCX decoder.
`default_nettype none
package xprd_pkg;

  localparam int HEADER_LEN_DEF = 128;
  localparam int MAX_PIXELS     = 1048576;

  localparam int PIX_W  = 21;
  localparam int BYTE_W = 8;
  localparam int RUN_W  = 6;
  localparam int IDX_W  = 2;

  localparam logic [PIX_W-1:0]  PIX_TOTAL_RST = 21'd64000;
  localparam logic [BYTE_W-1:0] MARKER_MIN    = 8'hC0;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_XOR_KEY       = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHECKSUM_SEED = 2'd1;
  localparam logic [IDX_W-1:0] REG_PIXEL_TOTAL   = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_CHECKSUM  = 2'd1;
  localparam logic [1:0] STS_OVERFLOW  = 2'd2;
  localparam logic [1:0] STS_FEW_PIXEL = 2'd3;

  typedef struct packed {
    logic take_ok;      // controller is ready for a new file byte
    logic run_step;     // emit the next pixel of a run
    logic status_emit;  // emit the end-of-file status
  } xprd_cmd_t;

  typedef struct packed {
    logic accept;    // file byte taken this cycle
    logic acc_more;  // that byte gives more than one pixel
    logic acc_last;  // that byte is the final one
    logic run_one;   // one run pixel left
    logic last_l;    // latched final flag of the byte in work
    logic out_free;  // output register can take a word this cycle
  } xprd_stat_t;

endpackage
`default_nettype wire

>>> src/xprd_if.sv
// Interfaces: file byte channel, result channel and configuration write channel.
`default_nettype none
interface xprd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       final_byte;

  modport source (output valid, raw_byte, final_byte, input ready);
  modport sink   (input valid, raw_byte, final_byte, output ready);
endinterface

interface xprd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       pixel_valid;
  logic       run_end;
  logic       status_valid;
  logic [1:0] status_code;
  logic [7:0] checksum_left;

  modport source (output valid, pixel_value, pixel_valid, run_end, status_valid,
                  status_code, checksum_left, input ready);
  modport sink   (input valid, pixel_value, pixel_valid, run_end, status_valid,
                  status_code, checksum_left, output ready);
endinterface

interface xprd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [20:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/xprd_ctrl.sv
// Controller: sequences byte intake, run pixel output and the status word.
`default_nettype none
module xprd_ctrl
  import xprd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire xprd_stat_t stat,
  output xprd_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_STATUS = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next      = state;
    cmd.take_ok     = 1'b0;
    cmd.run_step    = 1'b0;
    cmd.status_emit = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.take_ok = 1'b1;
        if (stat.accept) begin
          if (stat.acc_more) state_next = ST_RUN;
          else if (stat.acc_last) state_next = ST_STATUS;
        end
      end
      ST_RUN: begin
        cmd.run_step = stat.out_free;
        if (stat.out_free && stat.run_one) begin
          state_next = stat.last_l ? ST_STATUS : ST_IDLE;
        end
      end
      ST_STATUS: begin
        cmd.status_emit = stat.out_free;
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !stat.accept)
    else $error("byte taken outside idle");

  a_run_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.run_step |-> stat.out_free)
    else $error("run pixel issued with output full");

  a_status_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STATUS) |-> stat.last_l)
    else $error("status pending without a final byte");

endmodule
`default_nettype wire

>>> src/xprd_datapath.sv
// Datapath: config registers, checksum, header skip, run state and output register.
`default_nettype none
module xprd_datapath
  import xprd_pkg::*;
#(
  parameter int HEADER_LEN = HEADER_LEN_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire xprd_cmd_t cmd,
  output xprd_stat_t     stat,
  xprd_byte_if.sink      file_byte,
  xprd_result_if.source  result,
  xprd_cfg_if.sink       cfg
);

  localparam int HDR_W = $clog2(HEADER_LEN + 2);
  localparam logic [HDR_W-1:0] HDR_END = HDR_W'(HEADER_LEN);

  // configuration
  logic [BYTE_W-1:0] xor_key;
  logic [BYTE_W-1:0] checksum_seed;
  logic [PIX_W-1:0]  pixel_total;

  // file state
  logic [HDR_W-1:0]  header_count, header_count_next;
  logic [PIX_W-1:0]  pixels_done, pixels_done_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic              run_pending, run_pending_next;
  logic [RUN_W-1:0]  pending_length, pending_length_next;
  logic              overflow_seen, overflow_seen_next;

  // run in progress
  logic [BYTE_W-1:0] run_byte;
  logic [RUN_W-1:0]  run_left, run_left_next;
  logic              last_l;

  // output register
  logic              ovalid;
  logic [BYTE_W-1:0] o_pixel_value;
  logic              o_pixel_valid;
  logic              o_run_end;
  logic              o_status_valid;
  logic [1:0]        o_status_code;
  logic [BYTE_W-1:0] o_checksum_left;

  logic              out_free;
  logic              accept;
  logic [PIX_W-1:0]  total_eff;
  logic [BYTE_W-1:0] dec_byte;
  logic [RUN_W-1:0]  emit_cnt;
  logic [PIX_W:0]    run_reach;
  logic [1:0]        code;
  logic              cfg_wr;

  assign out_free       = !ovalid || result.ready;
  assign file_byte.ready = cmd.take_ok && out_free;
  assign accept         = file_byte.valid && file_byte.ready;
  assign cfg.ready      = 1'b1;
  assign cfg_wr         = cfg.valid;

  assign total_eff = (32'(pixel_total) > MAX_PIXELS) ? PIX_W'(MAX_PIXELS) : pixel_total;
  assign dec_byte  = file_byte.raw_byte ^ xor_key;
  assign run_reach = {1'b0, pixels_done} + (PIX_W + 1)'(dec_byte[RUN_W-1:0]);

  always_comb begin
    header_count_next   = header_count;
    pixels_done_next    = pixels_done;
    running_sum_next    = running_sum;
    run_pending_next    = run_pending;
    pending_length_next = pending_length;
    overflow_seen_next  = overflow_seen;
    emit_cnt            = '0;
    if (accept) begin
      running_sum_next = running_sum - file_byte.raw_byte;
      if (header_count < HDR_END) begin
        header_count_next = header_count + 1'b1;
      end else if (run_pending) begin
        emit_cnt            = pending_length;
        pixels_done_next    = pixels_done + PIX_W'(pending_length);
        run_pending_next    = 1'b0;
        pending_length_next = '0;
      end else if (!overflow_seen && (pixels_done < total_eff)) begin
        if (dec_byte >= MARKER_MIN) begin
          if ((run_reach > {1'b0, total_eff}) || file_byte.final_byte) begin
            overflow_seen_next = 1'b1;
          end else begin
            run_pending_next    = 1'b1;
            pending_length_next = dec_byte[RUN_W-1:0];
          end
        end else begin
          emit_cnt         = RUN_W'(1);
          pixels_done_next = pixels_done + 1'b1;
        end
      end
    end
    // seed write restarts the checksum
    if (cfg_wr && (cfg.index == REG_CHECKSUM_SEED)) begin
      running_sum_next = cfg.data[BYTE_W-1:0];
    end
  end

  // end-of-file status from the settled file state
  always_comb begin
    if (running_sum != '0)            code = STS_CHECKSUM;
    else if (overflow_seen)           code = STS_OVERFLOW;
    else if (pixels_done != total_eff) code = STS_FEW_PIXEL;
    else                              code = STS_OK;
  end

  assign run_left_next = accept ? (emit_cnt - 1'b1) : (run_left - 1'b1);

  assign stat.accept   = accept;
  assign stat.acc_more = emit_cnt > RUN_W'(1);
  assign stat.acc_last = file_byte.final_byte;
  assign stat.run_one  = run_left == RUN_W'(1);
  assign stat.last_l   = last_l;
  assign stat.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key        <= '0;
      checksum_seed  <= '0;
      pixel_total    <= PIX_TOTAL_RST;
      header_count   <= '0;
      pixels_done    <= '0;
      running_sum    <= '0;
      run_pending    <= 1'b0;
      pending_length <= '0;
      overflow_seen  <= 1'b0;
      run_left       <= '0;
      last_l         <= 1'b0;
      ovalid         <= 1'b0;
    end else begin
      if (cmd.status_emit) begin
        header_count   <= '0;
        pixels_done    <= '0;
        running_sum    <= checksum_seed;
        run_pending    <= 1'b0;
        pending_length <= '0;
        overflow_seen  <= 1'b0;
      end else begin
        header_count   <= header_count_next;
        pixels_done    <= pixels_done_next;
        running_sum    <= running_sum_next;
        run_pending    <= run_pending_next;
        pending_length <= pending_length_next;
        overflow_seen  <= overflow_seen_next;
      end
      if (accept || cmd.run_step) run_left <= run_left_next;
      if (accept) last_l <= file_byte.final_byte;

      if ((accept && (emit_cnt != '0)) || cmd.run_step || cmd.status_emit) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end

      if (cfg_wr) begin
        case (cfg.index)
          REG_XOR_KEY:       xor_key <= cfg.data[BYTE_W-1:0];
          REG_CHECKSUM_SEED: checksum_seed <= cfg.data[BYTE_W-1:0];
          REG_PIXEL_TOTAL:   pixel_total <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) run_byte <= dec_byte;
    if (accept && (emit_cnt != '0)) begin
      o_pixel_value   <= dec_byte;
      o_pixel_valid   <= 1'b1;
      o_run_end       <= (emit_cnt == RUN_W'(1)) && !file_byte.final_byte;
      o_status_valid  <= 1'b0;
      o_status_code   <= STS_OK;
      o_checksum_left <= '0;
    end else if (cmd.run_step) begin
      o_pixel_value   <= run_byte;
      o_pixel_valid   <= 1'b1;
      o_run_end       <= (run_left == RUN_W'(1)) && !last_l;
      o_status_valid  <= 1'b0;
      o_status_code   <= STS_OK;
      o_checksum_left <= '0;
    end else if (cmd.status_emit) begin
      o_pixel_value   <= '0;
      o_pixel_valid   <= 1'b0;
      o_run_end       <= 1'b1;
      o_status_valid  <= 1'b1;
      o_status_code   <= code;
      o_checksum_left <= running_sum;
    end
  end

  assign result.valid         = ovalid;
  assign result.pixel_value   = o_pixel_value;
  assign result.pixel_valid   = o_pixel_valid;
  assign result.run_end       = o_run_end;
  assign result.status_valid  = o_status_valid;
  assign result.status_code   = o_status_code;
  assign result.checksum_left = o_checksum_left;

  a_run_after_header: assert property (@(posedge clk) disable iff (rst)
    run_pending |-> (header_count == HDR_END))
    else $error("run pending inside header");

  a_run_left_live: assert property (@(posedge clk) disable iff (rst)
    cmd.run_step |-> (run_left != '0))
    else $error("run step with no pixels left");

  a_pixel_loaded: assert property (@(posedge clk) disable iff (rst)
    (accept && (emit_cnt != '0)) |=> (ovalid && o_pixel_valid && !o_status_valid))
    else $error("pixel of accepted byte not in output register");

endmodule
`default_nettype wire

>>> src/xor_pcx_rle_decoder.sv
// Top level: XOR-descrambling, checksumming 8-bit PCX run-length decoder.
//
// Channels (valid/ready, a word moves when both are high):
//   file_byte : one scrambled file byte per word, final_byte marks file end.
//   result    : decoded pixel words and one end-of-file status word per file;
//               run_end flags the last word caused by a given file byte.
//   cfg       : register writes (0 xor_key, 1 checksum_seed, 2 pixel_total),
//               always ready, one write per cycle; write only while idle.
// Timing: a literal pixel is loaded into the output register in the same cycle
// as its byte is taken, so it shows on result in the next cycle. A run of n
// pixels holds the byte channel until its last pixel is issued, one pixel per
// cycle while the output register is free, the first pixel loaded with the
// marker-following byte. Header, marker and zero-length-run bytes give no
// word. The final byte is followed by the status word. The single output
// register passes one word per cycle while the receiver is ready.
// Reset (rst, synchronous) clears the file state, loads the register
// defaults and empties the output register. When the receiver stalls, the
// output register holds its word and file_byte.ready stays low.
`default_nettype none
module xor_pcx_rle_decoder
  import xprd_pkg::*;
#(
  parameter int HEADER_LEN = HEADER_LEN_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  xprd_byte_if.sink     file_byte,
  xprd_result_if.source result,
  xprd_cfg_if.sink      cfg
);

  xprd_cmd_t  cmd;
  xprd_stat_t stat;

  // state machine: idle / run output / status output
  xprd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // checksum, descrambler, decode state and output register
  xprd_datapath #(
    .HEADER_LEN (HEADER_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .file_byte (file_byte),
    .result    (result),
    .cfg       (cfg)
  );

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for the scrambled PCX run-length decoder: directed files, then random files.
module tb
  import xprd_pkg::*;
();

  localparam int HDR_BYTES     = HEADER_LEN_DEF;
  localparam int LIMIT         = 5000000;  // timeout, far above the slowest correct run
  localparam int SETTLE_CYCLES = 4;        // marker/header bytes finish without a word
  localparam int TAIL_CYCLES   = 8;

  // index 3 maps to no register; a write there must change nothing
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  // one word on the result channel
  typedef struct packed {
    logic [7:0] pixel_value;
    logic       pixel_valid;
    logic       run_end;
    logic       status_valid;
    logic [1:0] status_code;
    logic [7:0] checksum_left;
  } word_t;

  // how a file is closed: checksum-fixing last byte, random last byte,
  // or a run marker as the last byte
  typedef enum {CLOSE_FIX, CLOSE_RANDOM, CLOSE_MARKER} close_t;

  logic clk;
  logic rst;

  xprd_byte_if   byte_ch ();
  xprd_result_if res_ch ();
  xprd_cfg_if    cfg_ch ();

  xor_pcx_rle_decoder #(
    .HEADER_LEN(HDR_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .file_byte(byte_ch),
    .result   (res_ch),
    .cfg      (cfg_ch)
  );

  // register copies kept by the decode model
  bit [7:0]  key_r;
  bit [7:0]  seed_r;
  bit [20:0] total_r;

  // per-file decode state
  int        hdr_seen;
  int        pix_done;
  int        run_len;
  bit        run_armed;
  bit        ovf;
  bit [7:0]  csum;

  word_t     expected_words[$];
  int        mismatches;
  int        body_items;      // bytes taken after the header
  int        cycles = 0;
  int        send_idle_pct;
  int        recv_stall_pct;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               expected_words.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------

  function automatic void restart_file();
    hdr_seen  = 0;
    pix_done  = 0;
    run_len   = 0;
    run_armed = 1'b0;
    ovf       = 1'b0;
    csum      = seed_r;
  endfunction

  function automatic word_t mk_word(bit [7:0] pix, bit pv, bit sv, bit [1:0] code,
                                    bit [7:0] residue);
    word_t w;
    w.pixel_value   = pix;
    w.pixel_valid   = pv;
    w.run_end       = 1'b0;
    w.status_valid  = sv;
    w.status_code   = code;
    w.checksum_left = residue;
    return w;
  endfunction

  // Works out the words one accepted file byte gives and queues them.
  function automatic void decode_byte(bit [7:0] raw, bit last);
    word_t    fresh[$];
    word_t    w;
    int       total;
    bit [7:0] b;
    bit [1:0] code;
    total = (total_r > MAX_PIXELS) ? MAX_PIXELS : int'(total_r);
    csum  = csum - raw;
    b     = raw ^ key_r;
    if (hdr_seen < HDR_BYTES) begin
      hdr_seen++;
    end else if (run_armed) begin
      // byte after a marker: repeated run_len times, zero allowed
      repeat (run_len) fresh.push_back(mk_word(b, 1'b1, 1'b0, STS_OK, 8'h00));
      pix_done += run_len;
      run_armed = 1'b0;
      run_len   = 0;
    end else if (!ovf && pix_done < total) begin
      if (b >= MARKER_MIN) begin
        // a run past the total, or a marker with no byte after it, stops decoding
        if (pix_done + int'(b[5:0]) > total || last) begin
          ovf = 1'b1;
        end else begin
          run_armed = 1'b1;
          run_len   = int'(b[5:0]);
        end
      end else begin
        fresh.push_back(mk_word(b, 1'b1, 1'b0, STS_OK, 8'h00));
        pix_done++;
      end
    end
    if (last) begin
      // checksum beats overflow, overflow beats a short image
      if (csum != 8'h00) code = STS_CHECKSUM;
      else if (ovf) code = STS_OVERFLOW;
      else if (pix_done != total) code = STS_FEW_PIXEL;
      else code = STS_OK;
      fresh.push_back(mk_word(8'h00, 1'b0, 1'b1, code, csum));
      restart_file();
    end
    if (fresh.size() > 0) begin
      w = fresh.pop_back();
      w.run_end = 1'b1;
      fresh.push_back(w);
    end
    foreach (fresh[i]) expected_words.push_back(fresh[i]);
  endfunction

  function automatic bit [7:0] scramble(bit [7:0] b);
    return b ^ key_r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls and the word checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 200)
      $display("mismatch on %s at cycle %0d: got 0x%0h, want 0x%0h", what, cycles, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", int'(res_ch.pixel_value), 0);
      end else begin
        want = expected_words.pop_front();
        if (res_ch.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", int'(res_ch.pixel_value),
                          int'(want.pixel_value));
        if (res_ch.pixel_valid !== want.pixel_valid)
          report_mismatch("pixel_valid", int'(res_ch.pixel_valid),
                          int'(want.pixel_valid));
        if (res_ch.run_end !== want.run_end)
          report_mismatch("run_end", int'(res_ch.run_end), int'(want.run_end));
        if (res_ch.status_valid !== want.status_valid)
          report_mismatch("status_valid", int'(res_ch.status_valid),
                          int'(want.status_valid));
        if (res_ch.status_code !== want.status_code)
          report_mismatch("status_code", int'(res_ch.status_code),
                          int'(want.status_code));
        if (res_ch.checksum_left !== want.checksum_left)
          report_mismatch("checksum_left", int'(res_ch.checksum_left),
                          int'(want.checksum_left));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte and register drivers
  // ---------------------------------------------------------------------------

  // Sends one file byte; valid stays high into the next byte unless a gap is drawn.
  task automatic send_byte(bit [7:0] raw, bit last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.raw_byte   <= raw;
    byte_ch.final_byte <= last;
    do @(posedge clk); while (!byte_ch.ready);
    if (hdr_seen == HDR_BYTES) body_items++;
    decode_byte(raw, last);
  endtask

  // Holds the byte channel until every queued word has come out.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // Idle point for register writes: drained, plus slack for wordless bytes.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, bit [20:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_XOR_KEY:       key_r = value[7:0];
      REG_CHECKSUM_SEED: begin
        // a seed write also reloads the running checksum
        seed_r = value[7:0];
        csum   = value[7:0];
      end
      REG_PIXEL_TOTAL:   total_r = value;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_header(bit zeros);
    repeat (HDR_BYTES) send_byte(zeros ? 8'h00 : 8'($urandom_range(255)), 1'b0);
  endtask

  task automatic close_file(close_t mode);
    bit [7:0] mark;
    case (mode)
      CLOSE_FIX:    send_byte(csum, 1'b1);  // brings the checksum to zero
      CLOSE_RANDOM: send_byte(8'($urandom_range(255)), 1'b1);
      default: begin
        mark = (8'hC0 | 8'($urandom_range(63))) ^ key_r;
        // optional pad so the marker still leaves a zero checksum
        if ($urandom_range(1)) send_byte(csum - mark, 1'b0);
        send_byte(mark, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Register defaults after reset: total 64000 is never reached, so a short image.
  task automatic test_defaults();
    send_header(1'b0);
    send_byte(scramble(8'h00), 1'b0);
    send_byte(scramble(8'hBF), 1'b0);
    close_file(CLOSE_FIX);
  endtask

  // Literal extremes, a zero-length run, a short run, bytes past the total.
  task automatic test_literals_and_runs();
    settle();
    write_reg(REG_XOR_KEY, 21'h0000FF);
    write_reg(REG_CHECKSUM_SEED, 21'h0000FF);
    write_reg(REG_PIXEL_TOTAL, 21'd5);
    send_header(1'b0);
    send_byte(scramble(8'hC0), 1'b0);  // zero-length run
    send_byte(scramble(8'h55), 1'b0);  // its data byte, no pixel
    send_byte(scramble(8'hC3), 1'b0);
    send_byte(scramble(8'hFF), 1'b0);  // three pixels of 0xFF
    send_byte(scramble(8'h00), 1'b0);
    send_byte(scramble(8'hBF), 1'b0);  // total reached here
    send_byte(8'h3C, 1'b0);            // decoding stopped: checksum only
    close_file(CLOSE_FIX);
  endtask

  // Run longer than what is left, then a full 63-pixel run ending on the last byte.
  task automatic test_overflow();
    send_header(1'b0);
    send_byte(scramble(8'hFF), 1'b0);
    send_byte(8'hA7, 1'b0);
    close_file(CLOSE_FIX);
    settle();
    write_reg(REG_XOR_KEY, 21'h000000);
    write_reg(REG_PIXEL_TOTAL, 21'd63);
    send_header(1'b0);
    send_byte(scramble(8'hFF), 1'b0);
    close_file(CLOSE_FIX);  // run data is the last byte: 63 pixels then status
  endtask

  // Zero total, clamped total with a marker as the last byte, and MAX_PIXELS.
  task automatic test_total_extremes();
    settle();
    write_reg(REG_PIXEL_TOTAL, 21'd0);
    send_header(1'b0);
    send_byte(scramble(8'h12), 1'b0);
    close_file(CLOSE_FIX);
    settle();
    write_reg(REG_CHECKSUM_SEED, 21'h000000);
    write_reg(REG_PIXEL_TOTAL, 21'h1FFFFF);
    // zero header, key 0, seed 0: 0x05 + 0x34 + 0xC7 sums to zero mod 256
    send_header(1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hC7, 1'b1);
    settle();
    write_reg(REG_PIXEL_TOTAL, 21'(MAX_PIXELS));
    send_header(1'b0);
    send_byte(scramble(8'h77), 1'b0);
    close_file(CLOSE_FIX);
  endtask

  // Bad checksum alone, and bad checksum together with an overflow.
  task automatic test_checksum_priority();
    settle();
    write_reg(REG_XOR_KEY, 21'h0000A5);
    write_reg(REG_PIXEL_TOTAL, 21'd1);
    send_header(1'b0);
    send_byte(scramble(8'h21), 1'b0);
    send_byte(csum ^ 8'h01, 1'b1);
    send_header(1'b0);
    send_byte(scramble(8'hC2), 1'b0);
    send_byte(csum + 8'd1, 1'b1);
  endtask

  // Seed written in the middle of a file reloads the running checksum.
  task automatic test_seed_reload();
    send_header(1'b0);
    settle();
    write_reg(REG_CHECKSUM_SEED, 21'h00005A);
    write_reg(REG_UNUSED, 21'h1FFFFF);
    send_byte(scramble(8'h40), 1'b0);
    close_file(CLOSE_FIX);
  endtask

  // ---------------------------------------------------------------------------
  // Random files
  // ---------------------------------------------------------------------------

  function automatic bit [7:0] pick_byte();
    bit [7:0] v;
    case ($urandom_range(9))
      0:       v = 8'h00;
      1:       v = 8'hFF;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  function automatic bit [20:0] pick_total();
    bit [20:0] v;
    case ($urandom_range(19))
      0:         v = '0;
      1:         v = 21'(MAX_PIXELS);
      2:         v = '1;
      3:         v = 21'($urandom);
      4, 5, 6:   v = 21'($urandom_range(400, 121));
      default:   v = 21'($urandom_range(120, 1));
    endcase
    return v;
  endfunction

  task automatic randomize_regs();
    settle();
    if ($urandom_range(1)) write_reg(REG_XOR_KEY, 21'(pick_byte()));
    if ($urandom_range(3) == 0) write_reg(REG_CHECKSUM_SEED, 21'(pick_byte()));
    if ($urandom_range(1)) write_reg(REG_PIXEL_TOTAL, pick_total());
  endtask

  // Mostly well-formed images of random content; the rest overflow runs,
  // noise bodies and marker endings.
  task automatic random_file(bit hold_before_close);
    bit [7:0] body[$];
    int       total;
    int       left;
    int       kind;
    int       cap;
    int       len;
    int       pause_at;
    bit       run_tail;
    close_t   mode;
    total    = (total_r > MAX_PIXELS) ? MAX_PIXELS : int'(total_r);
    left     = total;
    kind     = $urandom_range(9);
    mode     = ($urandom_range(6) == 0) ? CLOSE_RANDOM : CLOSE_FIX;
    run_tail = 1'b0;
    if (kind == 8) begin
      repeat ($urandom_range(30, 1)) body.push_back(8'($urandom_range(255)));
    end else begin
      cap = (kind < 7) ? 60 : $urandom_range(10);
      while (left > 0 && body.size() < cap) begin
        run_tail = ($urandom_range(2) == 0);
        if (run_tail) begin
          len = $urandom_range((left < 63) ? left : 63);
          body.push_back((8'hC0 | 8'(len)) ^ key_r);
          body.push_back(8'($urandom_range(255)));
          left -= len;
        end else begin
          body.push_back(8'($urandom_range(8'hBF)) ^ key_r);
          left--;
        end
      end
      if (kind == 7 && left < 63) begin
        body.push_back((8'hC0 | 8'($urandom_range(63, left + 1))) ^ key_r);
        run_tail = 1'b0;
      end
      if (kind == 9) mode = CLOSE_MARKER;
      else if (kind < 7 && run_tail && $urandom_range(1)) void'(body.pop_back());
      else repeat ($urandom_range(2)) body.push_back(8'($urandom_range(255)));
    end
    pause_at = ($urandom_range(9) == 0) ? $urandom_range(body.size()) : -1;
    send_header(1'b0);
    foreach (body[i]) begin
      if (i == pause_at) wait_drained();
      send_byte(body[i], 1'b0);
    end
    if (hold_before_close) wait_drained();
    close_file(mode);
  endtask

  // Four idling phases, about 85 body bytes each.
  task automatic test_random();
    int goal;
    bit first;
    first = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 0) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (ph == 1) begin
        send_idle_pct  = 80;
        recv_stall_pct = 0;
      end else if (ph == 2) begin
        send_idle_pct  = 0;
        recv_stall_pct = 80;
      end else begin
        send_idle_pct  = 25;
        recv_stall_pct = 25;
      end
      goal = body_items + 85;
      while (body_items < goal) begin
        randomize_regs();
        random_file(first);
        first = 1'b0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst                = 1'b1;
    byte_ch.valid      = 1'b0;
    byte_ch.raw_byte   = 8'h00;
    byte_ch.final_byte = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_XOR_KEY;
    cfg_ch.data        = '0;
    res_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    mismatches         = 0;
    body_items         = 0;
    key_r              = 8'h00;
    seed_r             = 8'h00;
    total_r            = PIX_TOTAL_RST;
    restart_file();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_literals_and_runs();
    test_overflow();
    test_total_extremes();
    test_checksum_priority();
    test_seed_reload();
    test_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
